// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("next-cycle implication violated");

`endif

// ===== rtl/u8bc_pkg.sv =====
// Types and constants of the UTF-8 buffer checker.
`timescale 1ns / 1ps

package u8bc_pkg;

  // Longest continuation run that a lead may announce (3 to 5).
  localparam int MAX_TAIL_BYTES = 5;

  // Lead byte bases: a lead with n continuations starts at LEAD_BASE_n.
  localparam logic [7:0] LEAD_MIN    = 8'hc2;
  localparam logic [7:0] LEAD_BASE_1 = 8'hc0;
  localparam logic [7:0] LEAD_BASE_2 = 8'he0;
  localparam logic [7:0] LEAD_BASE_3 = 8'hf0;
  localparam logic [7:0] LEAD_BASE_4 = 8'hf8;
  localparam logic [7:0] LEAD_BASE_5 = 8'hfc;
  localparam logic [7:0] LEAD_BASE_6 = 8'hfe;
  localparam logic [7:0] ASCII_TOP   = 8'h80;

  localparam logic [1:0] CONT_TAG = 2'b10;

  // Overlong limit for the first continuation: OVERLONG_BASE >> total tails.
  localparam logic [30:0] OVERLONG_BASE = 31'h80;

  // Point classes, on 31-bit points.
  localparam logic [30:0] ESC_MASK   = 31'h7fffff80;
  localparam logic [30:0] ESC_VALUE  = 31'h0000ef80;
  localparam logic [30:0] SURR_MASK  = 31'h7ffff800;
  localparam logic [30:0] SURR_VALUE = 31'h0000d800;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_req_t;

  typedef struct packed {
    logic        zero_seen;
    logic        malformed;
    logic        truncated;
    logic        escape_seen;
    logic        surrogate_seen;
    logic [30:0] max_point;
  } result_t;

  typedef struct packed {
    logic zero;
    logic bad;
    logic trunc;
    logic esc;
    logic surr;
  } flags_t;

  // Decoded lead byte.
  typedef struct packed {
    logic       zero;
    logic       bad;
    logic       start;
    logic [2:0] tails;
    logic [4:0] init;
  } lead_t;

endpackage

// ===== rtl/utf8_buffer_checker.sv =====
// Top level of the UTF-8 buffer checker: byte decoder, sticky flags, result register.
`timescale 1ns / 1ps
// The result request of a buffer is valid in the cycle after its last byte is taken.
// Throughput: one byte per cycle; a byte is taken in every cycle unless a finished
// result is held in the output register by result_stall.
// Reset (rst, synchronous, active high) clears the sequence state, the sticky flags,
// the largest point and the result valid bit.

module utf8_buffer_checker import u8bc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_stall,
  input  byte_req_t byte_req,
  output logic      result_valid,
  input  logic      result_stall,
  output result_t   result
);

  // Sequence state. tails_left of zero means no sequence is open.
  logic [2:0]  tails_left;
  logic [2:0]  tails_total;
  logic        first_tail_pending;
  logic [30:0] point_accum;
  flags_t      flags;
  logic [30:0] largest_point;

  logic [2:0]  tails_left_next;
  logic [2:0]  tails_total_next;
  logic        first_tail_pending_next;
  logic [30:0] point_accum_next;
  flags_t      flags_next;
  logic [30:0] largest_point_next;

  lead_t       lead;
  logic        cont;
  logic        in_seq;
  logic        overlong;
  logic [30:0] value;
  logic        rec_valid;
  logic [30:0] rec_point;
  logic        accept;

  // Classifies a byte parsed as the start of a sequence. A lead that calls
  // for more continuations than the block supports is malformed.
  function automatic lead_t decode_lead(input logic [7:0] c);
    lead_t      d;
    logic [7:0] base;
    d = '0;
    base = LEAD_BASE_1;
    if (c == 8'h00) begin
      d.zero = 1'b1;
    end else if (c < ASCII_TOP) begin
      d.start = 1'b0;
    end else if (c < LEAD_MIN || c >= LEAD_BASE_6) begin
      d.bad = 1'b1;
    end else begin
      if (c >= LEAD_BASE_5) begin
        d.tails = 3'd5;
        base = LEAD_BASE_5;
      end else if (c >= LEAD_BASE_4) begin
        d.tails = 3'd4;
        base = LEAD_BASE_4;
      end else if (c >= LEAD_BASE_3) begin
        d.tails = 3'd3;
        base = LEAD_BASE_3;
      end else if (c >= LEAD_BASE_2) begin
        d.tails = 3'd2;
        base = LEAD_BASE_2;
      end else begin
        d.tails = 3'd1;
      end
      d.init = 5'(c - base);
      if (d.tails > 3'(MAX_TAIL_BYTES)) begin
        d.bad = 1'b1;
        d.tails = '0;
      end else begin
        d.start = 1'b1;
      end
    end
    return d;
  endfunction

  // The input side only waits when a finished result is still held downstream.
  assign byte_stall = result_valid && result_stall;
  assign accept     = byte_valid && !byte_stall;

  always_comb begin
    lead     = decode_lead(byte_req.data_byte);
    cont     = byte_req.data_byte[7:6] == CONT_TAG;
    in_seq   = tails_left != 3'd0;
    value    = {point_accum[24:0], byte_req.data_byte[5:0]};
    overlong = first_tail_pending && (value < (OVERLONG_BASE >> tails_total));

    tails_left_next         = tails_left;
    tails_total_next        = tails_total;
    first_tail_pending_next = first_tail_pending;
    point_accum_next        = point_accum;
    flags_next              = flags;
    largest_point_next      = largest_point;
    rec_valid               = 1'b0;
    rec_point               = value;

    if (in_seq && cont && !overlong) begin
      // A good continuation extends the point; the last one completes it.
      point_accum_next        = value;
      first_tail_pending_next = 1'b0;
      tails_left_next         = tails_left - 3'd1;
      if (tails_left == 3'd1) begin
        rec_valid        = 1'b1;
        tails_total_next = '0;
        point_accum_next = '0;
      end
    end else begin
      // A broken or overlong sequence is dropped, and the byte starts over
      // as a lead.
      if (in_seq) begin
        flags_next.bad = 1'b1;
      end
      flags_next.zero         = flags_next.zero | lead.zero;
      flags_next.bad          = flags_next.bad | lead.bad;
      tails_left_next         = lead.tails;
      tails_total_next        = lead.tails;
      first_tail_pending_next = lead.start;
      point_accum_next        = lead.start ? 31'(lead.init) : '0;
    end

    // A buffer that ends inside a sequence still records the partial point.
    if (byte_req.last_byte && tails_left_next != 3'd0) begin
      flags_next.trunc = 1'b1;
      rec_valid        = 1'b1;
      rec_point        = point_accum_next;
    end

    if (rec_valid) begin
      if ((rec_point & ESC_MASK) == ESC_VALUE) begin
        flags_next.esc = 1'b1;
      end
      if ((rec_point & SURR_MASK) == SURR_VALUE) begin
        flags_next.surr = 1'b1;
      end
      if (rec_point > largest_point) begin
        largest_point_next = rec_point;
      end
    end
  end

  // State update. The last byte of a buffer hands its totals to the result
  // register and returns the state to its reset values.
  always_ff @(posedge clk) begin
    if (rst) begin
      tails_left         <= '0;
      tails_total        <= '0;
      first_tail_pending <= 1'b0;
      point_accum        <= '0;
      flags              <= '0;
      largest_point      <= '0;
    end else if (accept) begin
      if (byte_req.last_byte) begin
        tails_left         <= '0;
        tails_total        <= '0;
        first_tail_pending <= 1'b0;
        point_accum        <= '0;
        flags              <= '0;
        largest_point      <= '0;
      end else begin
        tails_left         <= tails_left_next;
        tails_total        <= tails_total_next;
        first_tail_pending <= first_tail_pending_next;
        point_accum        <= point_accum_next;
        flags              <= flags_next;
        largest_point      <= largest_point_next;
      end
    end
  end

  // Result register. It loads while empty or while its request is being taken,
  // which is exactly when byte_stall is low.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && byte_req.last_byte) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && byte_req.last_byte) begin
      result.zero_seen      <= flags_next.zero;
      result.malformed      <= flags_next.bad;
      result.truncated      <= flags_next.trunc;
      result.escape_seen    <= flags_next.esc;
      result.surrogate_seen <= flags_next.surr;
      result.max_point      <= largest_point_next;
    end
  end

endmodule

// ===== rtl/u8bc_check.sv =====
// Port checker of the UTF-8 buffer checker and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u8bc_check import u8bc_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      byte_valid,
  input logic      byte_stall,
  input byte_req_t byte_req,
  input logic      result_valid,
  input logic      result_stall,
  input result_t   result
);

  // A held result request stays valid and unchanged.
  `ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid)
  `ASSERT_NEXT(a_result_stable, clk, rst, result_valid && result_stall, $stable(result))

  // The last byte of a buffer always yields a result on the next cycle.
  `ASSERT_NEXT(a_last_gives_result, clk, rst,
               byte_valid && !byte_stall && byte_req.last_byte, result_valid)

  // Bytes are only held back by a result that is itself held back.
  `ASSERT_IMPLY(a_stall_cause, clk, rst, byte_stall, result_valid && result_stall)

endmodule

bind utf8_buffer_checker u8bc_check u_check (.*);
